@@ rtl/tll_pkg.sv @@
// Package for the TINY lexer: result record, scan modes, token classes and keyword table.
`default_nettype none
package tll_pkg;

  // Scan modes of the lexer.
  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_IDENT   = 2'd1,
    MODE_NUMBER  = 2'd2,
    MODE_COMMENT = 2'd3
  } mode_t;

  // Token class codes.
  localparam logic [4:0] CLS_IDENT   = 5'd0;
  localparam logic [4:0] CLS_KW_BASE = 5'd1;
  localparam logic [4:0] CLS_NUMBER  = 5'd9;
  localparam logic [4:0] CLS_OP_BASE = 5'd10;
  localparam logic [4:0] CLS_ILLEGAL = 5'd17;

  localparam int NUM_KW = 8;
  localparam int NUM_OP = 7;

  // Keyword spellings, first byte in the low bits, unused bytes zero.
  localparam logic [63:0] KW_TEXT [NUM_KW] = '{
    64'h0000_0000_0000_6669,  // if
    64'h0000_0000_6e65_6874,  // then
    64'h0000_0000_6573_6c65,  // else
    64'h0000_0000_0064_6e65,  // end
    64'h0000_7461_6570_6572,  // repeat
    64'h0000_006c_6974_6e75,  // until
    64'h0000_0000_6461_6572,  // read
    64'h0000_0065_7469_7277   // write
  };
  localparam logic [3:0] KW_LEN [NUM_KW] = '{
    4'd2, 4'd4, 4'd4, 4'd3, 4'd6, 4'd5, 4'd4, 4'd5
  };

  // Single-byte operators in class order.
  localparam logic [7:0] OP_CHAR [NUM_OP] = '{
    8'h2b, 8'h2d, 8'h2a, 8'h2f, 8'h3d, 8'h3c, 8'h3b
  };

  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_NEWLINE = 8'h0a;
  localparam logic [7:0] CH_LBRACE  = 8'h7b;
  localparam logic [7:0] CH_RBRACE  = 8'h7d;

  // One result word.
  typedef struct packed {
    logic [4:0]  token_class;
    logic [63:0] token_text;
    logic [3:0]  token_length;
    logic        truncated;
    logic [15:0] line_number;
    logic        last_of_run;
  } result_t;

  // What the scanner offers for the current byte.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } scan_out_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  // Class of a finished identifier: a keyword class or plain identifier.
  function automatic logic [4:0] kw_class(input logic [63:0] text, input logic [3:0] len);
    logic [4:0] cls;
    cls = CLS_IDENT;
    for (int i = 0; i < NUM_KW; i++) begin
      if (text == KW_TEXT[i] && len == KW_LEN[i]) begin
        cls = CLS_KW_BASE + 5'(i);
      end
    end
    return cls;
  endfunction

  // Class of a lone byte: an operator class or illegal.
  function automatic logic [4:0] byte_class(input logic [7:0] c);
    logic [4:0] cls;
    cls = CLS_ILLEGAL;
    for (int i = 0; i < NUM_OP; i++) begin
      if (c == OP_CHAR[i]) begin
        cls = CLS_OP_BASE + 5'(i);
      end
    end
    return cls;
  endfunction

endpackage
`default_nettype wire

@@ rtl/tll_char_if.sv @@
// Input channel of the lexer: one source byte or an end-of-input mark per word.
`default_nettype none
interface tll_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       end_of_input;

  modport source (output valid, output char_in, output end_of_input, input ready);
  modport sink (input valid, input char_in, input end_of_input, output ready);
endinterface
`default_nettype wire

@@ rtl/tll_token_if.sv @@
// Output channel of the lexer: one token per word.
`default_nettype none
interface tll_token_if;
  logic        valid;
  logic        ready;
  logic [4:0]  token_class;
  logic [63:0] token_text;
  logic [3:0]  token_length;
  logic        truncated;
  logic [15:0] line_number;
  logic        last_of_run;

  modport source (output valid, output token_class, output token_text, output token_length,
                  output truncated, output line_number, output last_of_run, input ready);
  modport sink (input valid, input token_class, input token_text, input token_length,
                input truncated, input line_number, input last_of_run, output ready);
endinterface
`default_nettype wire

@@ rtl/tll_scan.sv @@
// Scanner core: scan mode, word buffer and line count, with the tokens each byte yields.
`default_nettype none
module tll_scan
  import tll_pkg::*;
#(
  parameter int MAX_TOKEN = 8,
  parameter int LINE_BITS = 16
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step,
  input  wire logic [7:0] char_in,
  input  wire logic       end_of_input,
  output scan_out_t       scan
);

  localparam int LEN_BITS = $clog2(MAX_TOKEN + 1);
  localparam int IDX_BITS = $clog2(MAX_TOKEN);
  localparam int LW       = (LINE_BITS > 16) ? LINE_BITS : 16;

  mode_t                mode, mode_next;
  logic [7:0]           word_buf [MAX_TOKEN];
  logic [7:0]           word_buf_next [MAX_TOKEN];
  logic [LEN_BITS-1:0]  word_len, word_len_next;
  logic                 word_ovf, word_ovf_next;
  logic [LINE_BITS-1:0] line_count, line_count_next;

  logic [8*MAX_TOKEN-1:0] text_w;
  logic [63:0]            word_text;
  logic [LW-1:0]          line_wide;
  logic [15:0]            line_sat;
  result_t                flush_rec;
  result_t                lone_rec;
  logic [LINE_BITS-1:0]   line_inc;

  // Pending word as text, bytes past its length cleared.
  always_comb begin
    text_w = '0;
    for (int i = 0; i < MAX_TOKEN; i++) begin
      if (LEN_BITS'(i) < word_len) begin
        text_w[8*i +: 8] = word_buf[i];
      end
    end
    word_text = 64'(text_w);
  end

  // Line number as reported, saturating at the 16-bit limit.
  assign line_wide = LW'(line_count);
  assign line_sat  = (line_wide > LW'(17'h0ffff)) ? 16'hffff : line_wide[15:0];
  assign line_inc  = (line_count == '1) ? line_count : line_count + LINE_BITS'(1);

  // Token for the word being closed.
  always_comb begin
    flush_rec              = '0;
    flush_rec.token_text   = word_text;
    flush_rec.token_length = 4'(word_len);
    flush_rec.truncated    = word_ovf;
    flush_rec.line_number  = line_sat;
    if (mode == MODE_NUMBER) begin
      flush_rec.token_class = CLS_NUMBER;
    end else if (word_ovf) begin
      flush_rec.token_class = CLS_IDENT;
    end else begin
      flush_rec.token_class = kw_class(word_text, 4'(word_len));
    end
  end

  // Token for a byte that stands alone (operator or illegal).
  always_comb begin
    lone_rec              = '0;
    lone_rec.token_class  = byte_class(char_in);
    lone_rec.token_text   = 64'(char_in);
    lone_rec.token_length = 4'd1;
    lone_rec.line_number  = line_sat;
  end

  // Next state and tokens for the current byte.
  always_comb begin
    logic flush;
    logic fresh;
    logic append;
    logic lone;

    flush  = 1'b0;
    fresh  = 1'b0;
    append = 1'b0;
    lone   = 1'b0;

    mode_next       = mode;
    word_buf_next   = word_buf;
    word_len_next   = word_len;
    word_ovf_next   = word_ovf;
    line_count_next = line_count;

    if (end_of_input) begin
      flush         = (mode == MODE_IDENT) || (mode == MODE_NUMBER);
      mode_next     = MODE_IDLE;
      word_len_next = '0;
      word_ovf_next = 1'b0;
    end else begin
      unique case (mode)
        MODE_COMMENT: begin
          if (char_in == CH_RBRACE) begin
            mode_next = MODE_IDLE;
          end else if (char_in == CH_NEWLINE) begin
            line_count_next = line_inc;
          end
        end
        MODE_IDENT: begin
          if (is_letter(char_in)) begin
            append = 1'b1;
          end else begin
            flush = 1'b1;
            fresh = 1'b1;
          end
        end
        MODE_NUMBER: begin
          if (is_digit(char_in)) begin
            append = 1'b1;
          end else begin
            flush = 1'b1;
            fresh = 1'b1;
          end
        end
        MODE_IDLE: begin
          fresh = 1'b1;
        end
        default: begin
          fresh = 1'b1;
        end
      endcase
    end

    // A word that continues takes the byte, or notes the overflow.
    if (append) begin
      if (word_len < LEN_BITS'(MAX_TOKEN)) begin
        word_buf_next[word_len[IDX_BITS-1:0]] = char_in;
        word_len_next = word_len + LEN_BITS'(1);
      end else begin
        word_ovf_next = 1'b1;
      end
    end

    // A closed word resets the buffer before the byte is scanned afresh.
    if (flush && !end_of_input) begin
      mode_next     = MODE_IDLE;
      word_len_next = '0;
      word_ovf_next = 1'b0;
    end

    // Scanning a byte from the idle mode.
    if (fresh) begin
      if (is_letter(char_in) || is_digit(char_in)) begin
        mode_next        = is_letter(char_in) ? MODE_IDENT : MODE_NUMBER;
        word_buf_next[0] = char_in;
        word_len_next    = LEN_BITS'(1);
        word_ovf_next    = 1'b0;
      end else if (char_in == CH_LBRACE) begin
        mode_next = MODE_COMMENT;
      end else if (char_in == CH_SPACE || char_in == CH_TAB) begin
        mode_next = MODE_IDLE;
      end else if (char_in == CH_NEWLINE) begin
        line_count_next = line_inc;
      end else begin
        lone = 1'b1;
      end
    end

    // Pack the tokens in order, marking the last one.
    scan        = '0;
    scan.count  = 2'(flush) + 2'(lone);
    if (flush) begin
      scan.first = flush_rec;
      if (lone) begin
        scan.second             = lone_rec;
        scan.second.last_of_run = 1'b1;
      end else begin
        scan.first.last_of_run = 1'b1;
      end
    end else if (lone) begin
      scan.first             = lone_rec;
      scan.first.last_of_run = 1'b1;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_IDLE;
      word_len   <= '0;
      word_ovf   <= 1'b0;
      line_count <= LINE_BITS'(1);
    end else if (step) begin
      mode       <= mode_next;
      word_len   <= word_len_next;
      word_ovf   <= word_ovf_next;
      line_count <= line_count_next;
    end
  end

  // Word buffer, read only below the word length.
  always_ff @(posedge clk) begin
    if (step) begin
      word_buf <= word_buf_next;
    end
  end

endmodule
`default_nettype wire

@@ rtl/tiny_language_lexer_unit.sv @@
// Top level of the TINY lexer: input register, scanner and two-entry token queue.
//
//   channel  dir  word
//   chars    in   char_in[7:0], end_of_input
//   tokens   out  token_class, token_text, token_length, truncated, line_number, last_of_run
//
// One source byte is taken per cycle while chars.ready is high; a byte yields at
// most two tokens. Each byte is scanned from the input register and its tokens queued.
// A byte that yields two tokens waits in the input register whenever the queue
// already holds two tokens, since the queue drains at most one word per cycle.
// Reset clears the scan mode, word length and overflow and sets the line count to one.
// A stalled token side fills the queue, then the input register, then drops chars.ready.
`default_nettype none
module tiny_language_lexer_unit
  import tll_pkg::*;
#(
  parameter int MAX_TOKEN = 8,
  parameter int LINE_BITS = 16
) (
  input  wire logic    clk,
  input  wire logic    rst,
  tll_char_if.sink     chars,
  tll_token_if.source  tokens
);

  logic       hold_valid;
  logic [7:0] hold_char;
  logic       hold_eoi;

  scan_out_t  scan;
  logic       fire;
  logic       pop;

  result_t    queue [2];
  result_t    queue_next [2];
  logic [1:0] queue_count, queue_count_next;
  logic [1:0] kept;
  logic [2:0] needed;

  // The held byte is scanned once the queue can take all its tokens.
  assign pop    = tokens.ready && (queue_count != 2'd0);
  assign kept   = queue_count - 2'(pop);
  assign needed = 3'(kept) + 3'(scan.count);
  assign fire   = hold_valid && (needed <= 3'd2);

  assign chars.ready = !hold_valid || fire;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (chars.ready) begin
      hold_valid <= chars.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (chars.ready && chars.valid) begin
      hold_char <= chars.char_in;
      hold_eoi  <= chars.end_of_input;
    end
  end

  tll_scan #(
    .MAX_TOKEN (MAX_TOKEN),
    .LINE_BITS (LINE_BITS)
  ) u_scan (
    .clk          (clk),
    .rst          (rst),
    .step         (fire),
    .char_in      (hold_char),
    .end_of_input (hold_eoi),
    .scan         (scan)
  );

  // Token queue: pop the head, then append new tokens behind what is kept.
  always_comb begin
    queue_next[0] = pop ? queue[1] : queue[0];
    queue_next[1] = queue[1];
    if (fire) begin
      if (scan.count != 2'd0) begin
        queue_next[kept[0]] = scan.first;
      end
      if (scan.count == 2'd2) begin
        queue_next[1] = scan.second;
      end
    end
    queue_count_next = fire ? needed[1:0] : kept;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      queue_count <= 2'd0;
    end else begin
      queue_count <= queue_count_next;
    end
  end

  always_ff @(posedge clk) begin
    queue <= queue_next;
  end

  // Head of the queue drives the token channel.
  assign tokens.valid        = queue_count != 2'd0;
  assign tokens.token_class  = queue[0].token_class;
  assign tokens.token_text   = queue[0].token_text;
  assign tokens.token_length = queue[0].token_length;
  assign tokens.truncated    = queue[0].truncated;
  assign tokens.line_number  = queue[0].line_number;
  assign tokens.last_of_run  = queue[0].last_of_run;

endmodule
`default_nettype wire

@@ tb/tiny_language_lexer_unit_tb.sv @@
// Self-checking testbench for the TINY lexer: byte stimulus, token predictor and scoreboard.
`timescale 1ns / 1ps
module tiny_language_lexer_unit_tb;
  import tll_pkg::*;

  localparam int MAX_WORD     = 8;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 150;
  localparam int PHASE_WORDS  = 300;
  localparam logic [7:0] CH_CR = 8'h0d;

  // One row of the directed table; a typed row carries its token written out by hand.
  typedef struct {
    logic [7:0] ch;
    bit         eoi;
    bit         typed;
    result_t    want;
  } stim_row_t;

  logic clk;
  logic rst;

  tll_char_if  chars_if ();
  tll_token_if tokens_if ();

  tiny_language_lexer_unit u_dut (
    .clk    (clk),
    .rst    (rst),
    .chars  (chars_if),
    .tokens (tokens_if)
  );

  // Spellings used by the predictor for keyword and operator lookup.
  string kw_spell [NUM_KW] = '{"if", "then", "else", "end", "repeat", "until", "read", "write"};
  string op_glyphs = "+-*/=<;";

  // Predictor state.
  mode_t       scan_state;
  logic [7:0]  word_bytes [MAX_WORD];
  int unsigned word_fill;
  bit          word_spilled;
  logic [15:0] line_no;

  result_t     step_tokens [$];
  result_t     awaited_tokens [$];
  stim_row_t   stim_table [$];

  int errors;
  int words_sent;
  int tokens_checked;
  int keywords_seen;
  int truncated_seen;
  int tx_idle_pct;
  int rx_stall_pct;
  bit rx_hold;

  // Free-running clock, period 2 ns.
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Guard against a hung run.
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= 30) begin
      $display("%0t MISMATCH: %s", $time, what);
    end
  endtask

  function automatic bit alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit numeral(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  task automatic push_token(input logic [4:0] cls, input logic [63:0] text,
                            input logic [3:0] len, input bit trunc);
    result_t t;
    t.token_class  = cls;
    t.token_text   = text;
    t.token_length = len;
    t.truncated    = trunc;
    t.line_number  = line_no;
    t.last_of_run  = 1'b0;
    step_tokens.push_back(t);
  endtask

  // The line count saturates at the top of its range.
  task automatic bump_line();
    if (line_no != 16'hffff) begin
      line_no++;
    end
  endtask

  task automatic add_char(input logic [7:0] c);
    if (word_fill < MAX_WORD) begin
      word_bytes[word_fill] = c;
      word_fill++;
    end else begin
      word_spilled = 1'b1;
    end
  endtask

  // Finish the pending word; an untruncated identifier may turn out to be a keyword.
  task automatic close_word();
    logic [63:0] text;
    logic [4:0]  cls;
    bit          same;
    text = '0;
    for (int i = 0; i < word_fill; i++) begin
      text[8*i +: 8] = word_bytes[i];
    end
    cls = (scan_state == MODE_NUMBER) ? CLS_NUMBER : CLS_IDENT;
    if (scan_state == MODE_IDENT && !word_spilled) begin
      for (int k = 0; k < NUM_KW; k++) begin
        if (kw_spell[k].len() == word_fill) begin
          same = 1'b1;
          for (int i = 0; i < word_fill; i++) begin
            if (kw_spell[k][i] != word_bytes[i]) begin
              same = 1'b0;
            end
          end
          if (same) begin
            cls = CLS_KW_BASE + 5'(k);
          end
        end
      end
    end
    push_token(cls, text, 4'(word_fill), word_spilled);
    scan_state   = MODE_IDLE;
    word_fill    = 0;
    word_spilled = 1'b0;
  endtask

  // Scan a byte as if no word were pending.
  task automatic scan_fresh(input logic [7:0] c);
    logic [4:0] cls;
    if (alpha(c) || numeral(c)) begin
      scan_state   = alpha(c) ? MODE_IDENT : MODE_NUMBER;
      word_fill    = 0;
      word_spilled = 1'b0;
      add_char(c);
    end else if (c == CH_LBRACE) begin
      scan_state = MODE_COMMENT;
    end else if (c == CH_NEWLINE) begin
      bump_line();
    end else if (c != CH_SPACE && c != CH_TAB) begin
      cls = CLS_ILLEGAL;
      for (int i = 0; i < NUM_OP; i++) begin
        if (op_glyphs[i] == c) begin
          cls = CLS_OP_BASE + 5'(i);
        end
      end
      push_token(cls, 64'(c), 4'd1, 1'b0);
    end
  endtask

  // Work out the tokens that one accepted word gives, leaving them in step_tokens.
  task automatic predict_step(input logic [7:0] c, input bit eoi);
    result_t t;
    step_tokens.delete();
    if (eoi) begin
      if (scan_state == MODE_IDENT || scan_state == MODE_NUMBER) begin
        close_word();
      end
      scan_state = MODE_IDLE;
    end else begin
      case (scan_state)
        MODE_COMMENT: begin
          if (c == CH_RBRACE) begin
            scan_state = MODE_IDLE;
          end else if (c == CH_NEWLINE) begin
            bump_line();
          end
        end
        MODE_IDENT: begin
          if (alpha(c)) begin
            add_char(c);
          end else begin
            close_word();
            scan_fresh(c);
          end
        end
        MODE_NUMBER: begin
          if (numeral(c)) begin
            add_char(c);
          end else begin
            close_word();
            scan_fresh(c);
          end
        end
        default: begin
          scan_fresh(c);
        end
      endcase
    end
    if (step_tokens.size() > 0) begin
      t = step_tokens.pop_back();
      t.last_of_run = 1'b1;
      step_tokens.push_back(t);
    end
  endtask

  // Offer one word on the byte channel; called and left at a falling edge.
  task automatic send_char(input logic [7:0] c, input bit eoi,
                           input bit typed = 1'b0, input result_t want = '0);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      chars_if.valid <= 1'b0;
      @(negedge clk);
    end
    chars_if.valid        <= 1'b1;
    chars_if.char_in      <= c;
    chars_if.end_of_input <= eoi;
    do @(posedge clk); while (!chars_if.ready);
    predict_step(c, eoi);
    if (typed) begin
      awaited_tokens.push_back(want);
    end else begin
      foreach (step_tokens[i]) begin
        awaited_tokens.push_back(step_tokens[i]);
      end
    end
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i], 1'b0);
    end
  endtask

  function automatic logic [7:0] rand_letter();
    logic [7:0] r;
    r = 8'($urandom_range(0, 25));
    return ($urandom_range(0, 3) == 0) ? "A" + r : "a" + r;
  endfunction

  // Whitespace or an operator after a word, so that most words end cleanly.
  task automatic send_separator();
    case ($urandom_range(0, 3))
      0: send_char(CH_SPACE, 1'b0);
      1: send_char(CH_TAB, 1'b0);
      2: send_char(CH_NEWLINE, 1'b0);
      default: send_char(op_glyphs[$urandom_range(0, NUM_OP - 1)], 1'b0);
    endcase
  endtask

  // One random lexeme: mostly well-formed source text, with some noise.
  task automatic send_lexeme();
    int         pick;
    int         n;
    int         k;
    string      s;
    logic [7:0] b;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      k = $urandom_range(0, NUM_KW - 1);
      s = kw_spell[k];
      // Now and then a keyword with a capital letter, which is only an identifier.
      if ($urandom_range(0, 5) == 0) begin
        n = $urandom_range(0, s.len() - 1);
        s[n] = s[n] - 8'd32;
      end
      send_text(s);
      if ($urandom_range(0, 3) != 0) begin
        send_separator();
      end
    end else if (pick < 45) begin
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 8);
      repeat (n) send_char(rand_letter(), 1'b0);
      if ($urandom_range(0, 3) != 0) begin
        send_separator();
      end
    end else if (pick < 60) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 8);
      repeat (n) send_char("0" + 8'($urandom_range(0, 9)), 1'b0);
      if ($urandom_range(0, 3) != 0) begin
        send_separator();
      end
    end else if (pick < 75) begin
      send_char(op_glyphs[$urandom_range(0, NUM_OP - 1)], 1'b0);
    end else if (pick < 83) begin
      send_separator();
    end else if (pick < 89) begin
      // A brace comment with arbitrary bytes inside, sometimes cut off by end of input.
      send_char(CH_LBRACE, 1'b0);
      repeat ($urandom_range(0, 6)) begin
        b = 8'($urandom_range(0, 255));
        send_char((b == CH_RBRACE) ? CH_NEWLINE : b, 1'b0);
      end
      if ($urandom_range(0, 3) == 0) begin
        send_char(8'($urandom_range(0, 255)), 1'b1);
      end else begin
        send_char(CH_RBRACE, 1'b0);
      end
    end else if (pick < 95) begin
      send_char(8'($urandom_range(0, 255)), 1'b0);
    end else begin
      send_char(8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  // Hold the byte channel idle until every awaited token has come, then let the block settle.
  task automatic drain();
    chars_if.valid <= 1'b0;
    while (awaited_tokens.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic add_row(input logic [7:0] c, input bit eoi = 1'b0);
    stim_row_t r;
    r.ch    = c;
    r.eoi   = eoi;
    r.typed = 1'b0;
    r.want  = '0;
    stim_table.push_back(r);
  endtask

  // A row whose single token is written out by hand.
  task automatic add_typed(input logic [7:0] c, input logic [4:0] cls, input logic [15:0] line);
    stim_row_t r;
    r.ch                = c;
    r.eoi               = 1'b0;
    r.typed             = 1'b1;
    r.want              = '0;
    r.want.token_class  = cls;
    r.want.token_text   = 64'(c);
    r.want.token_length = 4'd1;
    r.want.line_number  = line;
    r.want.last_of_run  = 1'b1;
    stim_table.push_back(r);
  endtask

  // Token side: random stalls, or a long hold-off when asked.
  always @(negedge clk) begin
    if (rx_hold) begin
      tokens_if.ready <= 1'b0;
    end else begin
      tokens_if.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // Scoreboard: every accepted token is compared with the oldest awaited one.
  always @(posedge clk) begin
    result_t want;
    if (!rst && tokens_if.valid && tokens_if.ready) begin
      if (awaited_tokens.size() == 0) begin
        report_mismatch($sformatf("token class %0d arrived with none awaited",
                                  tokens_if.token_class));
      end else begin
        want = awaited_tokens.pop_front();
        tokens_checked++;
        if (want.token_class >= CLS_KW_BASE && want.token_class < CLS_NUMBER) begin
          keywords_seen++;
        end
        if (want.truncated) begin
          truncated_seen++;
        end
        if (tokens_if.token_class !== want.token_class) begin
          report_mismatch($sformatf("token_class got %0d want %0d",
                                    tokens_if.token_class, want.token_class));
        end
        if (tokens_if.token_text !== want.token_text) begin
          report_mismatch($sformatf("token_text got %h want %h",
                                    tokens_if.token_text, want.token_text));
        end
        if (tokens_if.token_length !== want.token_length) begin
          report_mismatch($sformatf("token_length got %0d want %0d",
                                    tokens_if.token_length, want.token_length));
        end
        if (tokens_if.truncated !== want.truncated) begin
          report_mismatch($sformatf("truncated got %b want %b",
                                    tokens_if.truncated, want.truncated));
        end
        if (tokens_if.line_number !== want.line_number) begin
          report_mismatch($sformatf("line_number got %0d want %0d",
                                    tokens_if.line_number, want.line_number));
        end
        if (tokens_if.last_of_run !== want.last_of_run) begin
          report_mismatch($sformatf("last_of_run got %b want %b",
                                    tokens_if.last_of_run, want.last_of_run));
        end
      end
    end
  end

  // Main sequence: directed table, idling phases, back-pressure and a final flush.
  initial begin
    int idle_tx [4] = '{0, 60, 0, 21};
    int stall_rx [4] = '{0, 0, 60, 21};
    int mark;
    string long_word;
    rst                   = 1'b1;
    chars_if.valid        = 1'b0;
    chars_if.char_in      = '0;
    chars_if.end_of_input = 1'b0;
    rx_hold               = 1'b0;
    tx_idle_pct           = 0;
    rx_stall_pct          = 0;
    errors                = 0;
    words_sent            = 0;
    tokens_checked        = 0;
    keywords_seen         = 0;
    truncated_seen        = 0;
    scan_state            = MODE_IDLE;
    word_fill             = 0;
    word_spilled          = 1'b0;
    line_no               = 16'd1;
    long_word             = "writewrit";

    // Directed table: operators and illegal bytes at the extremes, word switches,
    // comments across lines, a lone closing brace, a long word and end of input.
    add_typed("+", CLS_OP_BASE, 16'd1);
    add_typed(8'h00, CLS_ILLEGAL, 16'd1);
    add_typed(8'hff, CLS_ILLEGAL, 16'd1);
    add_row(CH_NEWLINE);
    add_row("i");
    add_row("f");
    add_row("9");
    add_row("A");
    add_row(CH_CR);
    add_row(CH_LBRACE);
    add_row(CH_NEWLINE);
    add_row(CH_RBRACE);
    add_typed(CH_RBRACE, CLS_ILLEGAL, 16'd3);
    for (int i = 0; i < long_word.len(); i++) begin
      add_row(long_word[i]);
    end
    add_row(";");
    add_row(CH_LBRACE);
    add_row(8'h5a, 1'b1);
    add_row(8'ha5, 1'b1);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (stim_table[i]) begin
      send_char(stim_table[i].ch, stim_table[i].eoi, stim_table[i].typed, stim_table[i].want);
    end

    // Random source text under each mix of sender gaps and receiver stalls.
    for (int p = 0; p < 4; p++) begin
      tx_idle_pct  = idle_tx[p];
      rx_stall_pct = stall_rx[p];
      mark = words_sent;
      while (words_sent - mark < PHASE_WORDS) begin
        send_lexeme();
      end
    end

    // Long hold-off on the token side while bytes keep coming, so the block backs up.
    tx_idle_pct  = 0;
    rx_stall_pct = 21;
    fork
      begin
        @(posedge clk);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold = 1'b0;
      end
      begin
        mark = words_sent;
        while (words_sent - mark < 60) begin
          send_char(op_glyphs[$urandom_range(0, NUM_OP - 1)], 1'b0);
          send_lexeme();
        end
      end
    join
    drain();

    // A short tail that ends with a keyword flushed by end of input.
    send_text("x");
    send_char(CH_NEWLINE, 1'b0);
    send_text("end");
    send_char(8'h00, 1'b1);
    drain();

    $display("Run covered %0d byte-channel words and %0d tokens (%0d keywords, %0d truncated),",
             words_sent, tokens_checked, keywords_seen, truncated_seen);
    $display("across idling mixes, a long token-side hold-off and end-of-input flushes.");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ tiny_language_lexer_unit.f @@
rtl/tll_pkg.sv
rtl/tll_char_if.sv
rtl/tll_token_if.sv
rtl/tll_scan.sv
rtl/tiny_language_lexer_unit.sv
tb/tiny_language_lexer_unit_tb.sv
